// ----- src/wpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpc_pkg
// Codes and action bits shared by the provisioning controller.
// ----------------------------------------------------------------------------
package wpc_pkg;

  // event codes
  typedef enum logic [3:0] {
    CMD_INIT        = 4'd0,
    CMD_TICK        = 4'd1,
    CMD_LOST        = 4'd2,
    CMD_ACTIVE_IP   = 4'd3,
    CMD_MANUAL      = 4'd4,
    CMD_RESET       = 4'd5,
    CMD_BEGIN_STAGE = 4'd6,
    CMD_STAGED_IP   = 4'd7,
    CMD_STAGED_FAIL = 4'd8,
    CMD_COMMIT      = 4'd9,
    CMD_AUTH_FAIL   = 4'd10,
    CMD_TAKE        = 4'd11
  } cmd_t;

  // controller modes
  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_CONN    = 3'd1,
    M_MAN_AP  = 3'd2,
    M_AUTO_AP = 3'd3,
    M_RETRY   = 3'd4,
    M_VALID   = 3'd5,
    M_COMMIT  = 3'd6,
    M_ONLINE  = 3'd7
  } mode_t;

  // reasons for entering setup
  typedef enum logic [2:0] {
    C_NONE     = 3'd0,
    C_NOCFG    = 3'd1,
    C_CORRUPT  = 3'd2,
    C_TIMEOUT  = 3'd3,
    C_NETRESET = 3'd4,
    C_BUTTON   = 3'd5,
    C_DASH     = 3'd6
  } cause_t;

  // setup session kinds
  typedef enum logic [1:0] {
    S_NONE   = 2'd0,
    S_AUTO   = 2'd1,
    S_MANUAL = 2'd2
  } sess_t;

  // stored configuration status on init
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_MIGRATED = 2'd1;
  localparam logic [1:0] ST_CORRUPT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_SETUP_ON_TIME   = 2'd1;
  localparam logic [1:0] REG_SETUP_OFF_TIME  = 2'd2;

  localparam int unsigned ACT_BITS = 15;

  // action mask bits
  localparam logic [ACT_BITS-1:0] A_CONNECT     = 15'h0001;
  localparam logic [ACT_BITS-1:0] A_SHOW_CONN   = 15'h0002;
  localparam logic [ACT_BITS-1:0] A_AP_START    = 15'h0004;
  localparam logic [ACT_BITS-1:0] A_AP_STOP     = 15'h0008;
  localparam logic [ACT_BITS-1:0] A_LOAD_KEY    = 15'h0010;
  localparam logic [ACT_BITS-1:0] A_SHOW_SETUP  = 15'h0020;
  localparam logic [ACT_BITS-1:0] A_SETUP_CUE   = 15'h0040;
  localparam logic [ACT_BITS-1:0] A_UNAVAIL     = 15'h0080;
  localparam logic [ACT_BITS-1:0] A_SHOW_OK     = 15'h0100;
  localparam logic [ACT_BITS-1:0] A_OK_CUE      = 15'h0200;
  localparam logic [ACT_BITS-1:0] A_CLEAR       = 15'h0400;
  localparam logic [ACT_BITS-1:0] A_STAGED_CONN = 15'h0800;
  localparam logic [ACT_BITS-1:0] A_COMMIT      = 15'h1000;
  localparam logic [ACT_BITS-1:0] A_DISCARD     = 15'h2000;
  localparam logic [ACT_BITS-1:0] A_AUTH_FAIL   = 15'h4000;

  // register reset values
  localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd15000;
  localparam logic [31:0] SETUP_ON_TIME_RST   = 32'd180000;
  localparam logic [31:0] SETUP_OFF_TIME_RST  = 32'd30000;

endpackage

// ----- src/wifi_provisioning_controller.sv -----
`timescale 1ns / 1ps
// The input register feeds one pass of next-state logic into the result register.
// Throughput: one item per cycle unless out_ready stalls the result register, which
// then holds the item in the input stage; the state update is one combinational pass.
// Reset: rst (synchronous) clears mode, flags, start times and the pending mask,
// and returns the three timing registers to their default values.
// ----------------------------------------------------------------------------
// wifi_provisioning_controller
// Event-driven provisioning controller with timeouts and a pending action mask.
// ----------------------------------------------------------------------------
module wifi_provisioning_controller #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [31:0] now_time,
  input  logic [1:0]  stored_status,
  input  logic        manual_source,
  input  logic        commit_ok,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic [2:0]  cause,
  output logic [1:0]  session_kind,
  output logic        ap_running,
  output logic        link_known,
  output logic        staged_held,
  output logic        accepted,
  output logic [14:0] actions
);
  import wpc_pkg::*;

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef struct packed {
    mode_t                 mode;
    cause_t                cause;
    sess_t                 sess;
    logic [TW-1:0]         mode_start;
    logic [TW-1:0]         session_start;
    logic                  ap;
    logic                  link;
    logic                  staged;
    logic [ACT_BITS-1:0]   pend;
  } ctl_t;

  // configuration registers
  logic [31:0] connect_timeout;
  logic [31:0] setup_on_time;
  logic [31:0] setup_off_time;

  // input register
  logic        in_q_valid;
  cmd_t        cmd_q;
  logic [31:0] now_q;
  logic [1:0]  status_q;
  logic        src_q;
  logic        ok_q;

  // controller state
  ctl_t ctl;
  ctl_t ctl_next;
  logic acc_next;
  logic [ACT_BITS-1:0] shown_next;

  logic advance;
  logic [CW-1:0] now_w;
  logic [TW-1:0] now_t;

  // timeout check on wrapping time difference
  function automatic logic passed(logic [TW-1:0] now, logic [TW-1:0] start,
                                  logic [31:0] dur);
    logic [TW-1:0] diff;
    diff = now - start;
    return CW'(diff) >= CW'(dur);
  endfunction

  function automatic ctl_t ap_on(ctl_t s);
    ctl_t r;
    r = s;
    if (!r.ap) begin
      r.ap = 1'b1;
      r.pend = r.pend | A_AP_START;
    end
    return r;
  endfunction

  function automatic ctl_t ap_off(ctl_t s);
    ctl_t r;
    r = s;
    if (r.ap) begin
      r.ap = 1'b0;
      r.pend = r.pend | A_AP_STOP;
    end
    return r;
  endfunction

  function automatic ctl_t go_connecting(ctl_t s, logic [TW-1:0] now);
    ctl_t r;
    r = ap_off(s);
    r.mode = M_CONN;
    r.cause = C_NONE;
    r.sess = S_NONE;
    r.mode_start = now;
    r.staged = 1'b0;
    r.pend = r.pend | A_CONNECT | A_SHOW_CONN;
    return r;
  endfunction

  function automatic ctl_t go_setup(ctl_t s, sess_t kind, cause_t why,
                                    logic [TW-1:0] now);
    ctl_t r;
    r = s;
    if (r.staged) begin
      r.staged = 1'b0;
      r.pend = r.pend | A_DISCARD;
    end
    r.sess = r.link ? kind : S_AUTO;
    r.mode = (r.sess == S_MANUAL) ? M_MAN_AP : M_AUTO_AP;
    r.cause = why;
    r.mode_start = now;
    r.session_start = now;
    r = ap_on(r);
    r.pend = r.pend | A_LOAD_KEY | A_SHOW_SETUP | A_SETUP_CUE;
    if (r.link) r.pend = r.pend | A_CONNECT;
    if (why == C_NOCFG || why == C_CORRUPT || why == C_TIMEOUT || why == C_NETRESET)
      r.pend = r.pend | A_UNAVAIL;
    return r;
  endfunction

  function automatic ctl_t go_retry(ctl_t s, logic [TW-1:0] now);
    ctl_t r;
    r = ap_off(s);
    r.mode = M_RETRY;
    r.mode_start = now;
    if (r.link) r.pend = r.pend | A_CONNECT | A_SHOW_CONN;
    else r.pend = r.pend | A_UNAVAIL;
    return r;
  endfunction

  function automatic ctl_t staged_failed(ctl_t s, logic [TW-1:0] now);
    ctl_t r;
    r = s;
    r.staged = 1'b0;
    r.pend = r.pend | A_DISCARD;
    if (r.sess == S_MANUAL && r.link) begin
      r.mode = M_MAN_AP;
    end else begin
      r.sess = S_AUTO;
      r.mode = M_AUTO_AP;
    end
    r.mode_start = now;
    r = ap_on(r);
    r.pend = r.pend | A_SHOW_SETUP;
    if (r.link) r.pend = r.pend | A_CONNECT;
    return r;
  endfunction

  function automatic ctl_t go_online(ctl_t s, logic [TW-1:0] now);
    ctl_t r;
    r = ap_off(s);
    r.mode = M_ONLINE;
    r.cause = C_NONE;
    r.sess = S_NONE;
    r.mode_start = now;
    r.pend = r.pend | A_SHOW_OK | A_OK_CUE;
    return r;
  endfunction

  // handshake: result register frees the input stage
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // event time at the state width
  assign now_w = CW'(now_q);
  assign now_t = now_w[TW-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      connect_timeout <= CONNECT_TIMEOUT_RST;
      setup_on_time   <= SETUP_ON_TIME_RST;
      setup_off_time  <= SETUP_OFF_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONNECT_TIMEOUT: connect_timeout <= cfg_data;
        REG_SETUP_ON_TIME:   setup_on_time   <= cfg_data;
        REG_SETUP_OFF_TIME:  setup_off_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q    <= cmd_t'(cmd);
      now_q    <= now_time;
      status_q <= stored_status;
      src_q    <= manual_source;
      ok_q     <= commit_ok;
    end
  end

  // next state for the event in the input register
  always_comb begin
    ctl_next = ctl;
    acc_next = 1'b0;
    case (cmd_q)
      CMD_INIT: begin
        ctl_next = '0;
        ctl_next.link = (status_q == ST_VALID || status_q == ST_MIGRATED);
        if (ctl_next.link) ctl_next = go_connecting(ctl_next, now_t);
        else ctl_next = go_setup(ctl_next, S_AUTO,
                                 (status_q == ST_CORRUPT) ? C_CORRUPT : C_NOCFG, now_t);
      end
      CMD_TICK: begin
        case (ctl.mode)
          M_CONN: begin
            if (passed(now_t, ctl.mode_start, connect_timeout))
              ctl_next = go_setup(ctl, S_AUTO, C_TIMEOUT, now_t);
          end
          M_MAN_AP: begin
            if (passed(now_t, ctl.session_start, setup_on_time)) begin
              if (ctl.link) begin
                ctl_next = go_connecting(ctl, now_t);
              end else begin
                ctl_next.sess = S_AUTO;
                ctl_next = go_retry(ctl_next, now_t);
              end
            end
          end
          M_AUTO_AP: begin
            if (passed(now_t, ctl.mode_start, setup_on_time))
              ctl_next = go_retry(ctl, now_t);
          end
          M_RETRY: begin
            if (passed(now_t, ctl.mode_start, setup_off_time)) begin
              ctl_next.mode = M_AUTO_AP;
              ctl_next.mode_start = now_t;
              ctl_next = ap_on(ctl_next);
              ctl_next.pend = ctl_next.pend | A_SHOW_SETUP;
            end
          end
          M_VALID: begin
            if (passed(now_t, ctl.mode_start, connect_timeout))
              ctl_next = staged_failed(ctl, now_t);
          end
          default: ;
        endcase
      end
      CMD_LOST: begin
        if (ctl.mode == M_ONLINE && ctl.link) ctl_next = go_connecting(ctl, now_t);
      end
      CMD_ACTIVE_IP: begin
        if (ctl.link && (ctl.mode == M_CONN || ctl.mode == M_AUTO_AP ||
                         ctl.mode == M_RETRY))
          ctl_next = go_online(ctl, now_t);
      end
      CMD_MANUAL: begin
        ctl_next = go_setup(ctl, S_MANUAL, src_q ? C_DASH : C_BUTTON, now_t);
      end
      CMD_RESET: begin
        ctl_next.link = 1'b0;
        ctl_next.pend = ctl_next.pend | A_CLEAR;
        ctl_next = go_setup(ctl_next, S_AUTO, C_NETRESET, now_t);
      end
      CMD_BEGIN_STAGE: begin
        if (ctl.ap && (ctl.mode == M_MAN_AP || ctl.mode == M_AUTO_AP)) begin
          ctl_next.mode = M_VALID;
          ctl_next.mode_start = now_t;
          ctl_next.staged = 1'b1;
          ctl_next.pend = ctl_next.pend | A_STAGED_CONN | A_SHOW_CONN;
          acc_next = 1'b1;
        end
      end
      CMD_STAGED_IP: begin
        if (ctl.mode == M_VALID && ctl.staged) begin
          ctl_next.mode = M_COMMIT;
          ctl_next.mode_start = now_t;
          ctl_next.pend = ctl_next.pend | A_COMMIT;
        end
      end
      CMD_STAGED_FAIL: begin
        if (ctl.mode == M_VALID) ctl_next = staged_failed(ctl, now_t);
      end
      CMD_COMMIT: begin
        if (ctl.mode == M_COMMIT) begin
          if (!ok_q) begin
            ctl_next = staged_failed(ctl, now_t);
          end else begin
            ctl_next.link = 1'b1;
            ctl_next.staged = 1'b0;
            ctl_next = go_online(ctl_next, now_t);
          end
        end
      end
      CMD_AUTH_FAIL: begin
        if (ctl.mode == M_ONLINE) ctl_next.pend = ctl_next.pend | A_AUTH_FAIL;
      end
      default: ;
    endcase
    // take hands the mask out and clears it
    shown_next = ctl_next.pend;
    if (cmd_q == CMD_TAKE) ctl_next.pend = '0;
  end

  // controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (advance) begin
      ctl <= ctl_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode         <= ctl_next.mode;
      cause        <= ctl_next.cause;
      session_kind <= ctl_next.sess;
      ap_running   <= ctl_next.ap;
      link_known   <= ctl_next.link;
      staged_held  <= ctl_next.staged;
      accepted     <= acc_next;
      actions      <= shown_next;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the provisioning controller: a queue-fed driver
// sends timestamped events with random gaps, a shadow controller predicts
// every result, and a monitor with random back-pressure compares them field
// by field. Timing registers are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import wpc_pkg::*;

  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned QUIET_LIMIT = 2000;

  // codes the package leaves unnamed
  localparam logic [1:0] ST_ABSENT    = 2'd3;
  localparam logic       SRC_BUTTON   = 1'b0;
  localparam logic       SRC_DASH     = 1'b1;
  localparam logic [3:0] CMD_SPARE_LO = 4'd12;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] stamp;
    logic [1:0]  status;
    logic        src;
    logic        ok;
    logic        hold;
  } evt_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  cause;
    logic [1:0]  sess;
    logic        ap;
    logic        link;
    logic        staged;
    logic        acc;
    logic [14:0] actions;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  cmd = 4'd0;
  logic [31:0] now_time = 32'd0;
  logic [1:0]  stored_status = 2'd0;
  logic        manual_source = 1'b0;
  logic        commit_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  mode;
  logic [2:0]  cause;
  logic [1:0]  session_kind;
  logic        ap_running;
  logic        link_known;
  logic        staged_held;
  logic        accepted;
  logic [14:0] actions;

  wifi_provisioning_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .now_time     (now_time),
    .stored_status(stored_status),
    .manual_source(manual_source),
    .commit_ok    (commit_ok),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mode         (mode),
    .cause        (cause),
    .session_kind (session_kind),
    .ap_running   (ap_running),
    .link_known   (link_known),
    .staged_held  (staged_held),
    .accepted     (accepted),
    .actions      (actions)
  );

  always #5 clk = ~clk;

  // bookkeeping
  evt_t        event_backlog[$];
  status_t     status_due[$];
  evt_t        cur_event;
  int unsigned queued_cnt = 0;
  int unsigned acc_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned setting_cnt = 1;
  int unsigned staged_ok_cnt = 0;
  int unsigned phase_goal = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned quiet = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  bit          pause_next = 1'b0;
  logic [31:0] t_now = 32'd0;

  // shadow controller state and timing copies
  mode_t       ctl_mode;
  cause_t      ctl_cause;
  sess_t       ctl_sess;
  logic [31:0] ctl_mode_t0;
  logic [31:0] ctl_sess_t0;
  logic        ctl_ap;
  logic        ctl_link;
  logic        ctl_staged;
  logic [14:0] ctl_actions;
  logic [31:0] lim_connect;
  logic [31:0] lim_ap_on;
  logic [31:0] lim_ap_off;

  // wrapping elapsed-time compare
  function automatic bit elapsed(input logic [31:0] now, input logic [31:0] since,
                                 input logic [31:0] span);
    logic [31:0] d;
    d = now - since;
    return d >= span;
  endfunction

  function automatic void ctl_clear();
    ctl_mode    = M_IDLE;
    ctl_cause   = C_NONE;
    ctl_sess    = S_NONE;
    ctl_mode_t0 = '0;
    ctl_sess_t0 = '0;
    ctl_ap      = 1'b0;
    ctl_link    = 1'b0;
    ctl_staged  = 1'b0;
    ctl_actions = '0;
  endfunction

  function automatic void ap_raise();
    if (!ctl_ap) begin
      ctl_ap = 1'b1;
      ctl_actions |= A_AP_START;
    end
  endfunction

  function automatic void ap_lower();
    if (ctl_ap) begin
      ctl_ap = 1'b0;
      ctl_actions |= A_AP_STOP;
    end
  endfunction

  function automatic void start_connecting(input logic [31:0] now);
    ap_lower();
    ctl_mode    = M_CONN;
    ctl_cause   = C_NONE;
    ctl_sess    = S_NONE;
    ctl_mode_t0 = now;
    ctl_staged  = 1'b0;
    ctl_actions |= A_CONNECT | A_SHOW_CONN;
  endfunction

  function automatic void enter_setup(input sess_t kind, input cause_t why,
                                      input logic [31:0] now);
    if (ctl_staged) begin
      ctl_staged = 1'b0;
      ctl_actions |= A_DISCARD;
    end
    // without a stored link every session is automatic
    ctl_sess    = ctl_link ? kind : S_AUTO;
    ctl_mode    = (ctl_sess == S_MANUAL) ? M_MAN_AP : M_AUTO_AP;
    ctl_cause   = why;
    ctl_mode_t0 = now;
    ctl_sess_t0 = now;
    ap_raise();
    ctl_actions |= A_LOAD_KEY | A_SHOW_SETUP | A_SETUP_CUE;
    if (ctl_link) ctl_actions |= A_CONNECT;
    if (why >= C_NOCFG && why <= C_NETRESET) ctl_actions |= A_UNAVAIL;
  endfunction

  function automatic void enter_retry(input logic [31:0] now);
    ap_lower();
    ctl_mode    = M_RETRY;
    ctl_mode_t0 = now;
    if (ctl_link) ctl_actions |= A_CONNECT | A_SHOW_CONN;
    else ctl_actions |= A_UNAVAIL;
  endfunction

  function automatic void staged_abort(input logic [31:0] now);
    ctl_staged = 1'b0;
    ctl_actions |= A_DISCARD;
    if (ctl_sess == S_MANUAL && ctl_link) begin
      ctl_mode = M_MAN_AP;
    end else begin
      ctl_sess = S_AUTO;
      ctl_mode = M_AUTO_AP;
    end
    ctl_mode_t0 = now;
    ap_raise();
    ctl_actions |= A_SHOW_SETUP;
    if (ctl_link) ctl_actions |= A_CONNECT;
  endfunction

  function automatic void enter_online(input logic [31:0] now);
    ap_lower();
    ctl_mode    = M_ONLINE;
    ctl_cause   = C_NONE;
    ctl_sess    = S_NONE;
    ctl_mode_t0 = now;
    ctl_actions |= A_SHOW_OK | A_OK_CUE;
  endfunction

  // apply one event to the shadow controller and return the status it reports
  function automatic status_t advance_controller(input evt_t ev);
    status_t     r;
    logic        took;
    logic [14:0] shown;
    took = 1'b0;
    case (ev.cmd)
      CMD_INIT: begin
        ctl_clear();
        ctl_link = (ev.status == ST_VALID) || (ev.status == ST_MIGRATED);
        if (ctl_link) start_connecting(ev.stamp);
        else enter_setup(S_AUTO, (ev.status == ST_CORRUPT) ? C_CORRUPT : C_NOCFG, ev.stamp);
      end
      CMD_TICK: begin
        case (ctl_mode)
          M_CONN: begin
            if (elapsed(ev.stamp, ctl_mode_t0, lim_connect))
              enter_setup(S_AUTO, C_TIMEOUT, ev.stamp);
          end
          M_MAN_AP: begin
            if (elapsed(ev.stamp, ctl_sess_t0, lim_ap_on)) begin
              if (ctl_link) begin
                start_connecting(ev.stamp);
              end else begin
                ctl_sess = S_AUTO;
                enter_retry(ev.stamp);
              end
            end
          end
          M_AUTO_AP: begin
            if (elapsed(ev.stamp, ctl_mode_t0, lim_ap_on)) enter_retry(ev.stamp);
          end
          M_RETRY: begin
            if (elapsed(ev.stamp, ctl_mode_t0, lim_ap_off)) begin
              ctl_mode    = M_AUTO_AP;
              ctl_mode_t0 = ev.stamp;
              ap_raise();
              ctl_actions |= A_SHOW_SETUP;
            end
          end
          M_VALID: begin
            if (elapsed(ev.stamp, ctl_mode_t0, lim_connect)) staged_abort(ev.stamp);
          end
          default: ;
        endcase
      end
      CMD_LOST: begin
        if (ctl_mode == M_ONLINE && ctl_link) start_connecting(ev.stamp);
      end
      CMD_ACTIVE_IP: begin
        if (ctl_link && (ctl_mode == M_CONN || ctl_mode == M_AUTO_AP ||
                         ctl_mode == M_RETRY))
          enter_online(ev.stamp);
      end
      CMD_MANUAL: begin
        enter_setup(S_MANUAL, (ev.src == SRC_BUTTON) ? C_BUTTON : C_DASH, ev.stamp);
      end
      CMD_RESET: begin
        ctl_link = 1'b0;
        ctl_actions |= A_CLEAR;
        enter_setup(S_AUTO, C_NETRESET, ev.stamp);
      end
      CMD_BEGIN_STAGE: begin
        if (ctl_ap && (ctl_mode == M_MAN_AP || ctl_mode == M_AUTO_AP)) begin
          ctl_mode    = M_VALID;
          ctl_mode_t0 = ev.stamp;
          ctl_staged  = 1'b1;
          ctl_actions |= A_STAGED_CONN | A_SHOW_CONN;
          took = 1'b1;
        end
      end
      CMD_STAGED_IP: begin
        if (ctl_mode == M_VALID && ctl_staged) begin
          ctl_mode    = M_COMMIT;
          ctl_mode_t0 = ev.stamp;
          ctl_actions |= A_COMMIT;
        end
      end
      CMD_STAGED_FAIL: begin
        if (ctl_mode == M_VALID) staged_abort(ev.stamp);
      end
      CMD_COMMIT: begin
        if (ctl_mode == M_COMMIT) begin
          if (!ev.ok) begin
            staged_abort(ev.stamp);
          end else begin
            ctl_link   = 1'b1;
            ctl_staged = 1'b0;
            enter_online(ev.stamp);
          end
        end
      end
      CMD_AUTH_FAIL: begin
        if (ctl_mode == M_ONLINE) ctl_actions |= A_AUTH_FAIL;
      end
      default: ;
    endcase
    // take reports the mask and clears it
    shown = ctl_actions;
    if (ev.cmd == CMD_TAKE) ctl_actions = '0;
    r.mode    = ctl_mode;
    r.cause   = ctl_cause;
    r.sess    = ctl_sess;
    r.ap      = ctl_ap;
    r.link    = ctl_link;
    r.staged  = ctl_staged;
    r.acc     = took;
    r.actions = shown;
    return r;
  endfunction

  // event generation
  task automatic push_full(input logic [3:0] c, input logic [31:0] stamp,
                           input logic [1:0] status, input logic src, input logic ok);
    evt_t ev;
    ev.cmd    = c;
    ev.stamp  = stamp;
    ev.status = status;
    ev.src    = src;
    ev.ok     = ok;
    ev.hold   = pause_next;
    pause_next = 1'b0;
    event_backlog.push_back(ev);
    queued_cnt++;
    t_now = stamp;
  endtask

  task automatic push_event(input logic [3:0] c, input logic [31:0] stamp);
    push_full(c, stamp, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // a tick exactly at a deadline, sometimes preceded by one just short of it
  task automatic tick_edge(input logic [31:0] due);
    if ($urandom_range(0, 1) == 1) push_event(CMD_TICK, due - 32'd1);
    push_event(CMD_TICK, due);
  endtask

  task automatic queue_directed();
    push_event(CMD_TICK, 32'h0);
    push_event(CMD_SPARE_LO, 32'h0);
    push_event(CMD_SPARE_HI, 32'hFFFF_FFFF);
    push_event(CMD_LOST, 32'd5);
    push_event(CMD_TAKE, 32'd6);
    // absent config just below the wrap point, then walk the setup cycle
    push_full(CMD_INIT, 32'hFFFF_FF00, ST_ABSENT, SRC_BUTTON, 1'b0);
    push_event(CMD_TICK, t_now + lim_ap_on - 32'd1);
    push_event(CMD_TICK, t_now + 32'd1);
    push_event(CMD_TICK, t_now + lim_ap_off);
    push_event(CMD_ACTIVE_IP, t_now + 32'd1);
    // staged config committed
    push_event(CMD_BEGIN_STAGE, t_now + 32'd1);
    push_event(CMD_STAGED_IP, t_now + 32'd1);
    push_full(CMD_COMMIT, t_now + 32'd1, ST_VALID, SRC_DASH, 1'b1);
    push_event(CMD_AUTH_FAIL, t_now + 32'd1);
    push_event(CMD_TAKE, t_now + 32'd1);
    push_event(CMD_LOST, t_now + 32'd1);
    push_event(CMD_TICK, t_now + lim_connect);
    // manual sessions from both sources
    push_full(CMD_MANUAL, t_now + 32'd1, ST_CORRUPT, SRC_BUTTON, 1'b1);
    push_event(CMD_BEGIN_STAGE, t_now + 32'd1);
    push_event(CMD_STAGED_FAIL, t_now + 32'd1);
    push_event(CMD_TICK, t_now + lim_ap_on - 32'd2);
    push_full(CMD_MANUAL, t_now + 32'd1, ST_ABSENT, SRC_DASH, 1'b0);
    push_event(CMD_BEGIN_STAGE, t_now + 32'd1);
    push_event(CMD_STAGED_IP, t_now + 32'd1);
    push_full(CMD_COMMIT, t_now + 32'd1, ST_ABSENT, SRC_DASH, 1'b0);
    push_event(CMD_RESET, t_now + 32'd1);
    push_full(CMD_INIT, t_now + 32'd1, ST_CORRUPT, SRC_BUTTON, 1'b0);
    push_full(CMD_INIT, t_now + 32'd1, ST_MIGRATED, SRC_BUTTON, 1'b0);
    push_full(CMD_INIT, t_now + 32'd1, ST_VALID, SRC_DASH, 1'b1);
    push_event(CMD_TAKE, t_now);
  endtask

  task automatic add_scenario(input bit must_pause);
    logic [31:0] t1;
    int unsigned n;
    case ($urandom_range(0, 3))
      0: t_now = t_now + $urandom_range(0, 100);
      1: t_now = t_now + $urandom_range(0, 4000);
      2: t_now = t_now + $urandom;
      default: t_now = t_now + $urandom_range(1000, 200000);
    endcase
    pause_next = must_pause || ($urandom_range(0, 24) == 0);
    case ($urandom_range(0, 9))
      0, 1: begin
        // boot, then run out connect, setup-on and setup-off times
        push_event(CMD_INIT, t_now);
        tick_edge(t_now + lim_connect);
        tick_edge(t_now + lim_ap_on);
        tick_edge(t_now + lim_ap_off);
        if ($urandom_range(0, 1) == 1) push_event(CMD_ACTIVE_IP, t_now + $urandom_range(0, 20));
      end
      2, 3: begin
        // manual session with a staged attempt
        push_event(CMD_MANUAL, t_now);
        t1 = t_now;
        if ($urandom_range(0, 3) != 0) begin
          push_event(CMD_BEGIN_STAGE, t_now + $urandom_range(0, 50));
          case ($urandom_range(0, 3))
            0, 1: begin
              push_event(CMD_STAGED_IP, t_now + $urandom_range(0, 50));
              push_event(CMD_COMMIT, t_now + $urandom_range(0, 50));
            end
            2: push_event(CMD_STAGED_FAIL, t_now + $urandom_range(0, 50));
            default: tick_edge(t_now + lim_connect);
          endcase
        end
        if ($urandom_range(0, 1) == 1) tick_edge(t1 + lim_ap_on);
      end
      4, 5: begin
        // stored link: online, gateway trouble, link loss
        if ($urandom_range(0, 1) == 1)
          push_full(CMD_INIT, t_now, ($urandom_range(0, 1) == 1) ? ST_VALID : ST_MIGRATED,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        push_event(CMD_ACTIVE_IP, t_now + $urandom_range(0, 50));
        push_event(CMD_AUTH_FAIL, t_now + $urandom_range(0, 50));
        push_event(CMD_LOST, t_now + $urandom_range(0, 50));
        tick_edge(t_now + lim_connect);
        push_event(CMD_ACTIVE_IP, t_now + $urandom_range(0, 50));
        if ($urandom_range(0, 1) == 1) push_event(CMD_LOST, t_now + $urandom_range(0, 50));
      end
      6: begin
        // network reset then a fresh staged config
        push_event(CMD_RESET, t_now);
        t1 = t_now;
        push_event(CMD_BEGIN_STAGE, t_now + $urandom_range(0, 50));
        push_event(CMD_STAGED_IP, t_now + $urandom_range(0, 50));
        push_event(CMD_COMMIT, t_now + $urandom_range(0, 50));
        if ($urandom_range(0, 1) == 1) tick_edge(t1 + lim_ap_on);
      end
      7: begin
        // setup cycling without a link
        push_event(CMD_RESET, t_now);
        tick_edge(t_now + lim_ap_on);
        tick_edge(t_now + lim_ap_off);
        push_event(CMD_ACTIVE_IP, t_now + $urandom_range(0, 50));
        tick_edge(t_now + lim_ap_on);
      end
      8: begin
        // unconstrained noise, spare codes included
        n = $urandom_range(1, 6);
        repeat (n) push_full(4'($urandom_range(0, 15)), $urandom, 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      default: begin
        // ticks at arbitrary times
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 1) == 1) push_event(CMD_TICK, t_now + $urandom_range(0, 5000));
          else push_event(CMD_TICK, $urandom);
        end
      end
    endcase
    if ($urandom_range(0, 1) == 1) push_event(CMD_TAKE, t_now);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (acc_cnt != queued_cnt || res_cnt != acc_cnt);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase();
    phase_goal += PHASE_ITEMS;
    add_scenario(1'b1);
    while (queued_cnt < phase_goal) add_scenario(1'b0);
    wait_drained();
  endtask

  // register writes, only while the controller is idle
  task automatic program_timing(input logic [31:0] ct, input logic [31:0] on,
                                input logic [31:0] off);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CONNECT_TIMEOUT;
    cfg_data  <= ct;
    @(posedge clk);
    cfg_index <= REG_SETUP_ON_TIME;
    cfg_data  <= on;
    @(posedge clk);
    cfg_index <= REG_SETUP_OFF_TIME;
    cfg_data  <= off;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_connect = ct;
    lim_ap_on   = on;
    lim_ap_off  = off;
    setting_cnt++;
  endtask

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        status_due.push_back(advance_controller(cur_event));
        acc_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (event_backlog.size() != 0 &&
                     !(event_backlog[0].hold && status_due.size() != 0)) begin
          cur_event = event_backlog.pop_front();
          cmd           <= cur_event.cmd;
          now_time      <= cur_event.stamp;
          stored_status <= cur_event.status;
          manual_source <= cur_event.src;
          commit_ok     <= cur_event.ok;
          in_valid      <= 1'b1;
          // gap before the next item, with calm stretches
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // result monitor with random back-pressure
  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        res_cnt++;
        if (status_due.size() == 0) begin
          $error("result item with no event waiting for it");
          fail_cnt++;
        end else begin
          want = status_due.pop_front();
          check_field("mode", 32'(want.mode), 32'(mode));
          check_field("cause", 32'(want.cause), 32'(cause));
          check_field("session_kind", 32'(want.sess), 32'(session_kind));
          check_field("ap_running", 32'(want.ap), 32'(ap_running));
          check_field("link_known", 32'(want.link), 32'(link_known));
          check_field("staged_held", 32'(want.staged), 32'(staged_held));
          check_field("accepted", 32'(want.acc), 32'(accepted));
          check_field("actions", 32'(want.actions), 32'(actions));
          if (want.acc) staged_ok_cnt++;
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 15);
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sequence of timing settings
  initial begin
    lim_connect = CONNECT_TIMEOUT_RST;
    lim_ap_on   = SETUP_ON_TIME_RST;
    lim_ap_off  = SETUP_OFF_TIME_RST;
    ctl_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    run_phase();
    program_timing(32'd1, 32'd1, 32'd1);
    run_phase();
    program_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase();
    program_timing($urandom_range(1, 300), $urandom_range(1, 3000), $urandom_range(1, 1000));
    run_phase();
    program_timing(32'd1, 32'hFFFF_FFFF, $urandom_range(1, 1000));
    run_phase();
    program_timing(32'hFFFF_FFFF, 32'd1, 32'd1);
    run_phase();
    program_timing(CONNECT_TIMEOUT_RST, SETUP_ON_TIME_RST, SETUP_OFF_TIME_RST);
    run_phase();
    program_timing($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 32'hFFFF_FFFF),
                   $urandom_range(1, 32'hFFFF_FFFF));
    run_phase();
    program_timing($urandom_range(1, 300), $urandom_range(1, 3000), $urandom_range(1, 1000));
    run_phase();

    repeat (10) @(negedge clk);
    if (status_due.size() != 0) begin
      $error("%0d expected results never arrived", status_due.size());
      fail_cnt++;
    end
    $display("%0d events sent under %0d timing settings, %0d results checked",
             acc_cnt, setting_cnt, res_cnt);
    $display("%0d staged validations were accepted along the way", staged_ok_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
